@@ hdl/mrts_pkg.sv @@
// Shared types and constants for the multi-register transfer sequencer.
package mrts_pkg;

    // Addressing mode codes of the instruction.
    localparam logic [1:0] MODE_OTHER   = 2'd0;
    localparam logic [1:0] MODE_POSTINC = 2'd1;
    localparam logic [1:0] MODE_PREDEC  = 2'd2;

    // Operation codes.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Width of the register mask and of a register number.
    localparam int MASK_W = 16;
    localparam int REG_W  = 4;

    // Transfer sizes in bytes.
    localparam logic [31:0] SIZE_WORD = 32'd2;
    localparam logic [31:0] SIZE_LONG = 32'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch a new instruction
        logic advance;   // produce one result and step to the next mask bit
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // the result about to be produced is the final one
    } t_dp_status;

endpackage

@@ hdl/multi_register_transfer_sequencer.sv @@
// Top level of the multi-register transfer sequencer.
//
// The block walks the register mask of one multi-register move and issues
// one result per set mask bit, each with a bus address and a register number.
// Input channel: i_valid with o_stall; an instruction is taken at a clock
// edge where i_valid is high and o_stall is low. o_stall stays high while an
// instruction is being walked, so one instruction is handled at a time.
// Output channel: o_valid with i_stall; a result is taken where o_valid is
// high and i_stall is low. The final result of an instruction carries o_last.
// The instruction is captured into the instruction registers, and its first result
// is then loaded into the result register. Throughput: one result per cycle while
// the receiver does not stall, one per set mask bit (one for an empty mask); the
// step is set by the mask walker, which clears one mask bit per result.
// A new instruction can be taken while the final result still waits.
// When the receiver stalls, the result register holds and the walk pauses.
// Reset clears the state machine and the output valid; no result is pending.
module multi_register_transfer_sequencer
    import mrts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic              i_long_size,
    input  logic [1:0]        i_address_mode,
    input  logic [2:0]        i_address_reg,
    input  logic [MASK_W-1:0] i_register_mask,
    input  logic [31:0]       i_start_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_transfer_valid,
    output logic [31:0]       o_bus_address,
    output logic [REG_W-1:0]  o_register_index,
    output logic              o_to_memory,
    output logic              o_sign_extend_word,
    output logic              o_update_address_reg,
    output logic [31:0]       o_updated_address,
    output logic              o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The address register number is applied by the consumer of the write-back.
    logic unused_address_reg;
    assign unused_address_reg = ^i_address_reg;

    // Sequencing control.
    mrts_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    // Mask walker, address counter and result register.
    mrts_datapath u_datapath (
        .i_clk                (i_clk),
        .i_cmd                (cmd),
        .i_operation          (i_operation),
        .i_long_size          (i_long_size),
        .i_address_mode       (i_address_mode),
        .i_register_mask      (i_register_mask),
        .i_start_address      (i_start_address),
        .o_status             (status),
        .o_transfer_valid     (o_transfer_valid),
        .o_bus_address        (o_bus_address),
        .o_register_index     (o_register_index),
        .o_to_memory          (o_to_memory),
        .o_sign_extend_word   (o_sign_extend_word),
        .o_update_address_reg (o_update_address_reg),
        .o_updated_address    (o_updated_address),
        .o_last               (o_last)
    );

endmodule

@@ hdl/mrts_controller.sv @@
// Controller state machine of the multi-register transfer sequencer.
module mrts_controller
    import mrts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_stall,
    output logic       o_valid
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic slot_free;

    // The output register can take a new result when it is empty or being emptied.
    assign slot_free = !r_out_valid || !i_stall;

    // Commands to the datapath.
    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_valid;
        o_cmd.advance = (r_state == ST_RUN) && slot_free;
    end

    // Next state: one instruction is worked on at a time.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (slot_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid follows the loading and the draining of the result register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !o_cmd.advance)
        else $error("result register overwritten while stalled");

    // A captured instruction always starts a run.
    a_capture_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_RUN) && !o_cmd.capture)
        else $error("capture did not start a run");

    // The final result returns the controller to idle with a result waiting.
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.advance && i_status.last) |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("final result did not end the run");

endmodule

@@ hdl/mrts_datapath.sv @@
// Datapath of the multi-register transfer sequencer: mask walker and address counter.
module mrts_datapath
    import mrts_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    input  logic              i_operation,
    input  logic              i_long_size,
    input  logic [1:0]        i_address_mode,
    input  logic [MASK_W-1:0] i_register_mask,
    input  logic [31:0]       i_start_address,
    output t_dp_status        o_status,
    output logic              o_transfer_valid,
    output logic [31:0]       o_bus_address,
    output logic [REG_W-1:0]  o_register_index,
    output logic              o_to_memory,
    output logic              o_sign_extend_word,
    output logic              o_update_address_reg,
    output logic [31:0]       o_updated_address,
    output logic              o_last
);

    // Instruction registers.
    logic [MASK_W-1:0] r_mask;
    logic [31:0]       r_addr;
    logic              r_load;
    logic              r_long;
    logic              r_predec_store;
    logic              r_writeback;
    logic              r_empty;

    logic [MASK_W-1:0] rest_mask;
    logic [REG_W-1:0]  low_bit;
    logic [31:0]       size;
    logic [31:0]       addr_plus;
    logic [31:0]       addr_minus;
    logic              is_last;

    // Lowest set bit of the remaining mask.
    always_comb begin
        low_bit = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_bit = REG_W'(i);
            end
        end
    end

    assign rest_mask  = r_mask & (r_mask - MASK_W'(1));
    assign size       = r_long ? SIZE_LONG : SIZE_WORD;
    assign addr_plus  = r_addr + size;
    assign addr_minus = r_addr - size;
    assign is_last    = r_empty || (rest_mask == '0);

    assign o_status.last = is_last;

    // Capture the instruction, then step through the mask one transfer at a time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask         <= i_register_mask;
            r_addr         <= i_start_address;
            r_load         <= i_operation;
            r_long         <= i_long_size;
            r_predec_store <= (i_operation == OP_STORE) && (i_address_mode == MODE_PREDEC);
            r_writeback    <= ((i_operation == OP_STORE) && (i_address_mode == MODE_PREDEC))
                           || ((i_operation == OP_LOAD) && (i_address_mode == MODE_POSTINC));
            r_empty        <= (i_register_mask == '0);
        end else if (i_cmd.advance) begin
            r_mask <= rest_mask;
            r_addr <= r_predec_store ? addr_minus : addr_plus;
        end
    end

    // Result register, loaded once per advance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            o_transfer_valid   <= !r_empty;
            o_bus_address      <= r_empty ? 32'd0 : r_addr;
            o_register_index   <= r_empty ? '0
                                : (r_predec_store ? (REG_W'(MASK_W - 1) - low_bit) : low_bit);
            o_to_memory        <= !r_load;
            o_sign_extend_word <= r_load && !r_long && !r_empty;
            o_update_address_reg <= r_writeback && is_last;
            // Write-back: the final transfer address for a predecrement store, one
            // size past the last transfer for a postincrement load; an empty list
            // swaps the two.
            if (r_writeback && is_last) begin
                o_updated_address <= (r_predec_store != r_empty) ? r_addr : addr_plus;
            end else begin
                o_updated_address <= 32'd0;
            end
            o_last <= is_last;
        end
    end

endmodule

@@ verif/multi_register_transfer_sequencer_tb.sv @@
// Self-checking testbench for the multi-register transfer sequencer.
module multi_register_transfer_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrts_pkg::*;

    // The spare addressing mode code behaves as the other control mode.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_PRINTED  = 40;

    // One expected result of a multi-register move.
    typedef struct packed {
        logic              transfer_valid;
        logic [31:0]       bus_address;
        logic [REG_W-1:0]  register_index;
        logic              to_memory;
        logic              sign_extend_word;
        logic              update_address_reg;
        logic [31:0]       updated_address;
        logic              last;
    } t_transfer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_operation = OP_STORE;
    logic              i_long_size = 1'b0;
    logic [1:0]        i_address_mode = MODE_OTHER;
    logic [2:0]        i_address_reg = '0;
    logic [MASK_W-1:0] i_register_mask = '0;
    logic [31:0]       i_start_address = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_transfer_valid;
    logic [31:0]       o_bus_address;
    logic [REG_W-1:0]  o_register_index;
    logic              o_to_memory;
    logic              o_sign_extend_word;
    logic              o_update_address_reg;
    logic [31:0]       o_updated_address;
    logic              o_last;

    t_transfer expected_transfers[$];
    int        error_count = 0;
    int        result_count = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;
    int        stall_burst_left = 0;
    bit        stall_burst_on = 1'b0;

    multi_register_transfer_sequencer u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_operation          (i_operation),
        .i_long_size          (i_long_size),
        .i_address_mode       (i_address_mode),
        .i_address_reg        (i_address_reg),
        .i_register_mask      (i_register_mask),
        .i_start_address      (i_start_address),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_transfer_valid     (o_transfer_valid),
        .o_bus_address        (o_bus_address),
        .o_register_index     (o_register_index),
        .o_to_memory          (o_to_memory),
        .o_sign_extend_word   (o_sign_extend_word),
        .o_update_address_reg (o_update_address_reg),
        .o_updated_address    (o_updated_address),
        .o_last               (o_last)
    );

    // Clock with a 12 ns period.
    always #6 i_clk = ~i_clk;

    // Run guard: a hung block must not hold the simulation forever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%08h, expected 0x%08h",
                                      result_count, field, got, want));
    endtask

    // Works out every result of one move and queues them in order.
    function automatic void predict_transfers(input logic op, input logic long_size,
                                              input logic [1:0] mode,
                                              input logic [MASK_W-1:0] register_mask,
                                              input logic [31:0] start_address);
        t_transfer   batch[$];
        t_transfer   item;
        logic [31:0] step;
        logic [31:0] cursor;
        logic [31:0] final_address;
        logic        predec_store;
        logic        write_back;
        step         = long_size ? SIZE_LONG : SIZE_WORD;
        predec_store = (op == OP_STORE) && (mode == MODE_PREDEC);
        write_back   = predec_store || (op == OP_LOAD && mode == MODE_POSTINC);
        cursor       = start_address;
        final_address = start_address;

        // An empty mask still produces a single closing result.
        if (register_mask == '0) begin
            item = '0;
            item.to_memory = (op == OP_STORE);
            item.last = 1'b1;
            item.update_address_reg = write_back;
            if (write_back)
                item.updated_address = predec_store ? start_address + step : start_address;
            expected_transfers.push_back(item);
            return;
        end

        // Predecrement stores number the mask from A7 down and walk downwards.
        for (int i = 0; i < MASK_W; i++) begin
            if (register_mask[i]) begin
                item = '0;
                item.transfer_valid   = 1'b1;
                item.bus_address      = cursor;
                item.register_index   = predec_store ? REG_W'(15 - i) : REG_W'(i);
                item.to_memory        = (op == OP_STORE);
                item.sign_extend_word = (op == OP_LOAD) && !long_size;
                final_address = cursor;
                cursor = predec_store ? cursor - step : cursor + step;
                batch.push_back(item);
            end
        end

        batch[batch.size() - 1].last = 1'b1;
        if (write_back) begin
            batch[batch.size() - 1].update_address_reg = 1'b1;
            batch[batch.size() - 1].updated_address = predec_store ? final_address : cursor;
        end
        foreach (batch[k])
            expected_transfers.push_back(batch[k]);
    endfunction

    // Offers one move, holds it until the transfer and then predicts it.
    task automatic send_instruction(input logic op, input logic long_size,
                                    input logic [1:0] mode, input logic [2:0] addr_reg,
                                    input logic [MASK_W-1:0] register_mask,
                                    input logic [31:0] start_address);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_long_size     <= long_size;
        i_address_mode  <= mode;
        i_address_reg   <= addr_reg;
        i_register_mask <= register_mask;
        i_start_address <= start_address;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_transfers(op, long_size, mode, register_mask, start_address);
    endtask

    // Receiver back-pressure: random stall bursts and free stretches.
    always @(posedge i_clk) begin
        if (!idle_on || !i_rst_n) begin
            stall_burst_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (stall_burst_left == 0) begin
                stall_burst_on   = ($urandom_range(0, 2) == 0);
                stall_burst_left = $urandom_range(1, 11);
            end
            stall_burst_left--;
            i_stall <= stall_burst_on;
        end
    end

    // Compares every accepted result against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_transfer want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_transfers.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_count));
            end else begin
                want = expected_transfers.pop_front();
                check_field("transfer_valid", 32'(o_transfer_valid),
                            32'(want.transfer_valid));
                check_field("bus_address", o_bus_address, want.bus_address);
                check_field("register_index", 32'(o_register_index),
                            32'(want.register_index));
                check_field("to_memory", 32'(o_to_memory), 32'(want.to_memory));
                check_field("sign_extend_word", 32'(o_sign_extend_word),
                            32'(want.sign_extend_word));
                check_field("update_address_reg", 32'(o_update_address_reg),
                            32'(want.update_address_reg));
                check_field("updated_address", o_updated_address, want.updated_address);
                check_field("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // Full masks in both directions, including the top mask bit on stores.
    task automatic test_full_masks();
        send_instruction(OP_STORE, 1'b1, MODE_PREDEC, 3'd7, 16'hFFFF, 32'h0000_1000);
        send_instruction(OP_LOAD, 1'b0, MODE_POSTINC, 3'd0, 16'hFFFF, 32'hFFFF_FFF0);
        send_instruction(OP_STORE, 1'b0, MODE_OTHER, 3'd5, 16'hFFFF, 32'hFFFF_FFFF);
        send_instruction(OP_LOAD, 1'b1, MODE_OTHER, 3'd2, 16'hFFFF, 32'h0000_0000);
    endtask

    // Empty masks give one closing result, with or without write-back.
    task automatic test_empty_masks();
        send_instruction(OP_STORE, 1'b0, MODE_PREDEC, 3'd3, 16'h0000, 32'h0000_4000);
        send_instruction(OP_LOAD, 1'b1, MODE_POSTINC, 3'd4, 16'h0000, 32'h8000_0000);
        send_instruction(OP_LOAD, 1'b0, MODE_OTHER, 3'd1, 16'h0000, 32'h1234_5678);
        send_instruction(OP_STORE, 1'b1, MODE_OTHER, 3'd6, 16'h0000, 32'hFFFF_FFFF);
        send_instruction(OP_LOAD, 1'b0, MODE_PREDEC, 3'd0, 16'h0000, 32'h0000_0010);
    endtask

    // Mode and direction pairs: four walk upwards without write-back, two write back.
    task automatic test_mode_direction_pairs();
        send_instruction(OP_STORE, 1'b1, MODE_POSTINC, 3'd2, 16'h8001, 32'h0000_0100);
        send_instruction(OP_LOAD, 1'b0, MODE_PREDEC, 3'd3, 16'h8000, 32'h0000_0200);
        send_instruction(OP_LOAD, 1'b1, MODE_UNUSED, 3'd7, 16'hAAAA, 32'hFFFF_FFFF);
        send_instruction(OP_STORE, 1'b0, MODE_UNUSED, 3'd1, 16'h5555, 32'h0000_0000);
        send_instruction(OP_LOAD, 1'b0, MODE_POSTINC, 3'd5, 16'h0001, 32'h5555_5555);
        send_instruction(OP_STORE, 1'b0, MODE_PREDEC, 3'd6, 16'h8000, 32'hAAAA_AAAA);
    endtask

    // Address arithmetic wrapping past zero in both directions.
    task automatic test_address_wrap();
        send_instruction(OP_STORE, 1'b1, MODE_PREDEC, 3'd4, 16'h0003, 32'h0000_0002);
        send_instruction(OP_LOAD, 1'b1, MODE_POSTINC, 3'd7, 16'hFFFF, 32'hFFFF_FFC0);
        send_instruction(OP_STORE, 1'b0, MODE_PREDEC, 3'd2, 16'h0000, 32'hFFFF_FFFE);
        send_instruction(OP_STORE, 1'b0, MODE_PREDEC, 3'd0, 16'hF00F, 32'h0000_0004);
    endtask

    // Random moves: mostly random masks, with sparse, full and empty ones mixed in.
    task automatic test_random_moves(input int count);
        logic [1:0]        mode;
        logic [MASK_W-1:0] register_mask;
        logic [31:0]       start_address;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       register_mask = '0;
                1, 2:    register_mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
                3:       register_mask = '1;
                default: register_mask = MASK_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:          mode = MODE_UNUSED;
                1, 2, 3:    mode = MODE_OTHER;
                4, 5, 6:    mode = MODE_POSTINC;
                default:    mode = MODE_PREDEC;
            endcase
            case ($urandom_range(0, 5))
                0:       start_address = 32'($urandom_range(0, 63));
                1:       start_address = 32'hFFFF_FFFF - 32'($urandom_range(0, 63));
                default: start_address = $urandom;
            endcase
            send_instruction($urandom_range(0, 1) ? OP_LOAD : OP_STORE,
                             1'($urandom_range(0, 1)), mode, 3'($urandom_range(0, 7)),
                             register_mask, start_address);
        end
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_random_back_to_back(input int count);
        idle_on = 1'b0;
        test_random_moves(count);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_masks();
        test_empty_masks();
        test_mode_direction_pairs();
        test_address_wrap();
        test_random_moves(280);
        test_random_back_to_back(25);
        i_valid <= 1'b0;

        // Let every predicted result drain, then allow for stragglers.
        while (expected_transfers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_transfers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mrts_pkg.sv
hdl/mrts_controller.sv
hdl/mrts_datapath.sv
hdl/multi_register_transfer_sequencer.sv
verif/multi_register_transfer_sequencer_tb.sv
